[rtl/mt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt_pkg
// Constants, types and the tempering function of the MT19937 word generator.
// ----------------------------------------------------------------------------
package mt_pkg;

  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned SHIFT_OFFSET = 397;
  localparam int unsigned POS_W        = $clog2(STATE_WORDS);

  localparam logic [31:0] TWIST_XOR    = 32'h9908_b0df;
  localparam logic [31:0] TOP_BIT      = 32'h8000_0000;
  localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
  localparam logic [31:0] SEED_MULT    = 32'd1812433253;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [31:0] SEED_DEFAULT = 32'd5489;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(STATE_WORDS - 1);
  localparam logic [POS_W-1:0] OFFSET   = POS_W'(SHIFT_OFFSET);
  localparam logic [POS_W-1:0] WRAP     = POS_W'(STATE_WORDS);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SEED = 6'b000010,
    ST_RD1  = 6'b000100,
    ST_RD2  = 6'b001000,
    ST_CALC = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

[rtl/mt_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module mt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/mt19937_word_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt19937_word_generator
// Standard 32-bit Mersenne Twister with the state kept in a block RAM.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                Payload
//  in_      slave      in_tvalid / in_tready    in_tdata[0]   = reseed
//  out_     master     out_tvalid / out_tready  out_tdata     = random_word
//  cfg_     write      cfg_we                   cfg_wdata     = seed_value
//
// A plain draw reads the neighbor word, then the word 397 places ahead, through
// the single RAM read port, writes the twist back and tempers it; the input is
// not ready again until that word has gone to the output register. A seeding
// draw (reseed set, or the first draw after reset) first writes words 1 to 623
// one a cycle. Reset loads 5489 as seed; a held output word stalls the next
// draw and the input.
//
module mt19937_word_generator (
  input  logic        clk,
  input  logic        rst_n,
  // Input words: bit 0 reseed, bits 7:1 unused.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // Output words: bits 31:0 random_word.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  // Seed register write.
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int unsigned PW = mt_pkg::POS_W;

  mt_pkg::state_t state_r, state_nxt;

  logic [31:0]   seed_r;
  logic          seeded_r, seeded_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] k_r, k_nxt;
  logic [31:0]   prev_r, prev_nxt;
  // Holds the current word at the read position; it was fetched as the
  // neighbor word during the previous draw, or is the seed itself.
  logic [31:0]   cur_r, cur_nxt;
  logic [31:0]   nbr_r, nbr_nxt;
  logic [31:0]   w_r, w_nxt;
  logic [31:0]   out_data_r, out_data_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [PW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  logic [PW-1:0] nxt_pos;
  logic [PW-1:0] far_sum;
  logic [PW-1:0] far_pos;
  logic [31:0]   seed_mix;
  logic [31:0]   seed_word;
  logic [31:0]   mix_y;
  logic [31:0]   twist_w;
  logic          accept;

  mt_ram #(
    .WIDTH (32),
    .DEPTH (mt_pkg::STATE_WORDS)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign in_tready  = (state_r == mt_pkg::ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Neighbor and far positions of the current read position.
  assign nxt_pos = (pos_r == mt_pkg::LAST_POS) ? '0 : pos_r + PW'(1);
  assign far_sum = pos_r + mt_pkg::OFFSET;
  assign far_pos = (far_sum >= mt_pkg::WRAP) ? far_sum - mt_pkg::WRAP : far_sum;

  // Seeding recurrence: one multiply by a constant and one add per word.
  assign seed_mix  = prev_r ^ (prev_r >> 30);
  assign seed_word = (mt_pkg::SEED_MULT * seed_mix) + {{(32 - PW){1'b0}}, k_r};

  // Twist of one word; ram_rdata holds the far word in the compute cycle.
  assign mix_y   = (cur_r & mt_pkg::TOP_BIT) | (nbr_r & mt_pkg::LOW_BITS);
  assign twist_w = ram_rdata ^ (mix_y >> 1) ^ (mix_y[0] ? mt_pkg::TWIST_XOR : '0);

  always_comb begin
    state_nxt     = state_r;
    seeded_nxt    = seeded_r;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    nbr_nxt       = nbr_r;
    w_nxt         = w_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = twist_w;
    ram_raddr     = nxt_pos;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      mt_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_tdata[0] || !seeded_r) begin
            // Word 0 of the store is the seed itself.
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = seed_r;
            prev_nxt  = seed_r;
            cur_nxt   = seed_r;
            k_nxt     = PW'(1);
            state_nxt = mt_pkg::ST_SEED;
          end else begin
            state_nxt = mt_pkg::ST_RD1;
          end
        end
      end
      mt_pkg::ST_SEED: begin
        ram_we    = 1'b1;
        ram_waddr = k_r;
        ram_wdata = seed_word;
        prev_nxt  = seed_word;
        k_nxt     = k_r + PW'(1);
        if (k_r == mt_pkg::LAST_POS) begin
          pos_nxt    = '0;
          seeded_nxt = 1'b1;
          state_nxt  = mt_pkg::ST_RD1;
        end
      end
      mt_pkg::ST_RD1: begin
        ram_raddr = nxt_pos;
        state_nxt = mt_pkg::ST_RD2;
      end
      mt_pkg::ST_RD2: begin
        ram_raddr = far_pos;
        nbr_nxt   = ram_rdata;
        state_nxt = mt_pkg::ST_CALC;
      end
      mt_pkg::ST_CALC: begin
        // Only the current word is written; the neighbor and far words are
        // at other addresses, so no forwarding is needed.
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = twist_w;
        w_nxt     = twist_w;
        cur_nxt   = nbr_r;
        pos_nxt   = nxt_pos;
        state_nxt = mt_pkg::ST_OUT;
      end
      mt_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = mt_pkg::temper(w_r);
          out_valid_nxt = 1'b1;
          state_nxt     = mt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mt_pkg::ST_IDLE;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
      seed_r      <= mt_pkg::SEED_DEFAULT;
      pos_r       <= '0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      seeded_r    <= seeded_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      k_r         <= k_nxt;
      if (cfg_we) begin
        seed_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    nbr_r      <= nbr_nxt;
    w_r        <= w_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
